>>> rtl/three_axis_pid_drone_command_macros.svh
// Assertion helpers for the RTL files.
`ifndef THREE_AXIS_PID_DRONE_COMMAND_MACROS_SVH
`define THREE_AXIS_PID_DRONE_COMMAND_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TAPDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TAPDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tapdc_pkg.sv
package tapdc_pkg;

	localparam int CMD_W       = 11;
	localparam int PERIOD_FRAC = 8;
	localparam int OPA_W       = 33;
	localparam int OPB_W       = 17;
	localparam int PROD_W      = OPA_W + OPB_W;

	localparam int CMD_CENTER = 1500;
	localparam int CMD_MIN    = 1000;
	localparam int CMD_MAX    = 2000;

	localparam logic [15:0] INV_RESET = 16'd7758;

	// configuration register indexes
	localparam logic [1:0] REG_PITCH_GAINS    = 2'd0;
	localparam logic [1:0] REG_ROLL_GAINS     = 2'd1;
	localparam logic [1:0] REG_THROTTLE_GAINS = 2'd2;
	localparam logic [1:0] REG_INV_TIME       = 2'd3;

	typedef logic signed [31:0]       fx_t;
	typedef logic [47:0]              gains_t;
	typedef logic [CMD_W-1:0]         cmd_t;
	typedef logic signed [OPA_W-1:0]  opa_t;
	typedef logic signed [OPB_W-1:0]  opb_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// floor-shift a difference*period product and saturate to 32 bits
	function automatic fx_t sat_rate(input prod_t p);
		prod_t s;
		s = p >>> PERIOD_FRAC;
		if (s[PROD_W-1:31] == '0 || s[PROD_W-1:31] == '1)
			return s[31:0];
		else if (s[PROD_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

>>> rtl/three_axis_pid_drone_command.sv
// Channel | Beat content                                   | Handshake
// --------+------------------------------------------------+---------------------------
// in      | offset_x, offset_y, offset_z (Q16.16)          | in_valid / in_ready
// out     | pitch/roll/throttle_cmd, rate_x/y/z            | out_valid / out_ready
// cfg     | cfg_index, cfg_wdata (gains, 1/dt)             | cfg_wr_en, no wait
//
// Each input beat is worked through the three axes in turn and then published; the
// next beat is taken only once the sequencer is back in idle. The work is set by the
// single 33x17 multiplier that serves all fifteen products in turn.
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so a new beat may be taken while the previous one is unclaimed.
// A stalled output holds the sequencer at its final step until the slot frees up.
// Reset clears the sequencer, the valid flag, the history flag and the gain registers, and loads 1/dt with INV_RESET.
`include "three_axis_pid_drone_command_macros.svh"

module three_axis_pid_drone_command
	import tapdc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  fx_t         offset_x,
	input  fx_t         offset_y,
	input  fx_t         offset_z,
	output logic        out_valid,
	input  logic        out_ready,
	output cmd_t        pitch_cmd,
	output cmd_t        roll_cmd,
	output cmd_t        throttle_cmd,
	output fx_t         rate_x,
	output fx_t         rate_y,
	output fx_t         rate_z,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);

	// total shift from the gain products back to whole pulse units
	localparam int SH    = FRAC_BITS + PERIOD_FRAC;
	localparam int ACC_W = ((CMD_W + 1 + SH) > 48 ? (CMD_W + 1 + SH) : 48) + 3;
	localparam logic signed [ACC_W-1:0] CENTER_FX = $signed(ACC_W'(CMD_CENTER)) <<< SH;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// steps within one axis; operands pass the operand registers, then the product register, before a step uses the result
	localparam logic [3:0] SP_LOAD_DPOS  = 4'd0;
	localparam logic [3:0] SP_RATE       = 4'd2;
	localparam logic [3:0] SP_LOAD_DRATE = 4'd3;
	localparam logic [3:0] SP_ACCEL      = 4'd5;
	localparam logic [3:0] SP_LOAD_KI    = 4'd6;
	localparam logic [3:0] SP_SUM_KP     = 4'd7;
	localparam logic [3:0] SP_SUM_KI     = 4'd8;
	localparam logic [3:0] SP_SUM_KD     = 4'd9;
	localparam logic [3:0] SP_CLAMP      = 4'd10;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	// configuration
	gains_t      gains_q [3];
	logic [15:0] inv_q;

	// sequencer
	logic [1:0]  state_q;
	logic [1:0]  axis_q;
	logic [3:0]  step_q;
	logic        primed_q;

	// working data
	fx_t         pos_q      [3];
	fx_t         last_pos_q [3];
	fx_t         last_rate_q[3];
	cmd_t        cmd_w_q    [3];
	fx_t         rate_q;
	fx_t         accel_q;
	opa_t        opa_q;
	opb_t        opb_q;
	prod_t       prod_q;
	logic signed [ACC_W-1:0] sum_q;

	// output slot
	logic        out_valid_q;
	cmd_t        pitch_q, roll_q, throttle_q;
	fx_t         rate_x_q, rate_y_q, rate_z_q;

	gains_t      gsel;
	opb_t        kp, ki, kd;
	fx_t         pos_cur;
	fx_t         neg_z;
	cmd_t        cmd_next;
	logic signed [ACC_W-1:0] sum_shift;

	assign gsel    = gains_q[axis_q];
	assign kp      = {gsel[15], gsel[15:0]};
	assign ki      = {gsel[31], gsel[31:16]};
	assign kd      = {gsel[47], gsel[47:32]};
	assign pos_cur = pos_q[axis_q];
	// negating the most negative z saturates
	assign neg_z   = (offset_z == 32'sh8000_0000) ? 32'sh7fff_ffff : -offset_z;

	// clamp the weighted sum to the pulse range
	assign sum_shift = sum_q >>> SH;
	always_comb begin
		if (sum_q[ACC_W-1])
			cmd_next = cmd_t'(CMD_MIN);
		else if (sum_shift < ACC_W'(CMD_MIN))
			cmd_next = cmd_t'(CMD_MIN);
		else if (sum_shift > ACC_W'(CMD_MAX))
			cmd_next = cmd_t'(CMD_MAX);
		else
			cmd_next = sum_shift[CMD_W-1:0];
	end

	// shared multiplier, registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= opa_q * opb_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q[0] <= '0;
			gains_q[1] <= '0;
			gains_q[2] <= '0;
			inv_q      <= INV_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PITCH_GAINS:    gains_q[0] <= cfg_wdata;
				REG_ROLL_GAINS:     gains_q[1] <= cfg_wdata;
				REG_THROTTLE_GAINS: gains_q[2] <= cfg_wdata;
				REG_INV_TIME:       inv_q      <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			step_q      <= '0;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken; a publish below overrides
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						axis_q  <= '0;
						step_q  <= SP_LOAD_DPOS;
					end
				end
				ST_RUN: begin
					if (step_q == SP_CLAMP) begin
						step_q <= SP_LOAD_DPOS;
						if (axis_q == AXIS_LAST) begin
							axis_q   <= '0;
							state_q  <= ST_DONE;
							primed_q <= 1'b1;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					// publish once the output slot is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pos_q[0] <= offset_x;
			pos_q[1] <= offset_y;
			pos_q[2] <= neg_z;
		end
		if (state_q == ST_RUN) begin
			case (step_q)
				SP_LOAD_DPOS: begin
					opa_q <= {pos_cur[31], pos_cur} - {last_pos_q[axis_q][31], last_pos_q[axis_q]};
					opb_q <= {1'b0, inv_q};
				end
				SP_RATE: begin
					rate_q <= primed_q ? sat_rate(prod_q) : '0;
				end
				SP_LOAD_DRATE: begin
					opa_q <= {rate_q[31], rate_q}
						- {last_rate_q[axis_q][31], last_rate_q[axis_q]};
					opb_q <= {1'b0, inv_q};
					last_rate_q[axis_q] <= rate_q;
					last_pos_q[axis_q]  <= pos_cur;
				end
				SP_ACCEL: begin
					accel_q <= primed_q ? sat_rate(prod_q) : '0;
					opa_q   <= {rate_q[31], rate_q};
					opb_q   <= kp;
				end
				SP_LOAD_KI: begin
					opa_q <= {pos_cur[31], pos_cur};
					opb_q <= ki;
				end
				SP_SUM_KP: begin
					sum_q <= CENTER_FX + ACC_W'(prod_q);
					opa_q <= {accel_q[31], accel_q};
					opb_q <= kd;
				end
				SP_SUM_KI: sum_q <= sum_q + ACC_W'(prod_q);
				SP_SUM_KD: sum_q <= sum_q + ACC_W'(prod_q);
				SP_CLAMP:  cmd_w_q[axis_q] <= cmd_next;
				default: ;
			endcase
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			pitch_q    <= cmd_w_q[0];
			roll_q     <= cmd_w_q[1];
			throttle_q <= cmd_w_q[2];
			rate_x_q   <= last_rate_q[0];
			rate_y_q   <= last_rate_q[1];
			rate_z_q   <= last_rate_q[2];
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign pitch_cmd    = pitch_q;
	assign roll_cmd     = roll_q;
	assign throttle_cmd = throttle_q;
	assign rate_x       = rate_x_q;
	assign rate_y       = rate_y_q;
	assign rate_z       = rate_z_q;

	`TAPDC_ASSERT_NXT(a_accept_starts_run, clk, arst_n, in_valid && in_ready,
		state_q == ST_RUN && axis_q == 2'd0 && step_q == SP_LOAD_DPOS,
		"accepted beat did not start the sequencer at the first step")
	`TAPDC_ASSERT_IMP(a_step_bound, clk, arst_n, state_q == ST_RUN,
		step_q <= SP_CLAMP && axis_q <= AXIS_LAST, "sequencer step or axis out of range")
	`TAPDC_ASSERT_IMP(a_done_primed, clk, arst_n, state_q == ST_DONE, primed_q,
		"history not marked after a finished item")
	`TAPDC_ASSERT_IMP(a_cmd_range, clk, arst_n, out_valid,
		pitch_cmd >= 11'd1000 && pitch_cmd <= 11'd2000
		&& roll_cmd >= 11'd1000 && roll_cmd <= 11'd2000
		&& throttle_cmd >= 11'd1000 && throttle_cmd <= 11'd2000,
		"command outside the pulse range")

endmodule
